### hw/rtl/bamm_pkg.sv
// ----------------------------------------------------------------------------
// bamm_pkg
// Types and constants shared by the brake actuator mode mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package bamm_pkg;

  localparam logic [11:0] NEUTRAL_PWM    = 12'd1500;
  localparam logic [10:0] NEUTRAL_RADIO  = 11'd1500;
  localparam logic [10:0] CAL_LOW_RESET  = 11'd363;
  localparam logic [10:0] CAL_HIGH_RESET = 11'd1641;
  localparam logic [11:0] OUT_MIN_RESET  = 12'd1000;
  localparam logic [11:0] OUT_MAX_RESET  = 12'd2000;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_RADIO = 3'd1,
    REQ_AUTO  = 3'd2,
    REQ_BRAIN = 3'd3,
    REQ_CALIB = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_CAL    = 2'd3
  } mode_t;

  // brain state codes, plus a marker for "none seen yet"
  localparam logic [2:0] BRAIN_IDLE   = 3'd0;
  localparam logic [2:0] BRAIN_MANUAL = 3'd1;
  localparam logic [2:0] BRAIN_AUTO   = 3'd2;
  localparam logic [2:0] BRAIN_NONE   = 3'd4;

  typedef enum logic [0:0] {
    CFG_OUTPUT_MIN = 1'd0,
    CFG_OUTPUT_MAX = 1'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_AFIN,
    ST_DIVP,
    ST_DIVN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [10:0]        radio_value;
    logic signed [15:0] autopilot_norm;
    logic [1:0]         brain_state;
    logic               calib_enable;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        pwm;
    logic signed [15:0] norm;
  } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/brake_actuator_mode_mapper.sv
// Path to out_valid: idle tick or zero-span radio sample straight to ST_DONE, autopilot
//   value via ST_MUL0 and ST_AFIN, manual radio sample via two multiply steps, a 12-step
//   pwm divide and a 17-step norm divide, all on one multiplier and one divider.
// Flow: one item at a time; in_stall is high until the item's result is in the output
//   register; items without a result leave in_stall low.
// Reset: mode idle, no brain state seen, bounds 363/1641, limits 1000/2000, output empty.
// ----------------------------------------------------------------------------
// brake_actuator_mode_mapper
// Mode tracking, radio calibration and pulse-width mapping for a brake
// actuator, with a shared multiplier and restoring divider under a sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module brake_actuator_mode_mapper (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  bamm_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output bamm_pkg::out_item_t     out_data,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire                     cfg_index,
  input  wire [11:0]              cfg_data
);
  import bamm_pkg::*;

  logic [11:0] omin_r, omax_r;
  mode_t       mode_r, mode_nxt;
  logic [2:0]  last_brain_r, last_brain_nxt;
  logic [10:0] cal_low_r, cal_low_nxt, cal_high_r, cal_high_nxt;

  seq_state_t  state_r, state_nxt;
  logic        is_auto_r, is_auto_nxt;
  logic [10:0] d_r, d_nxt, span_r, span_nxt;
  logic [15:0] apb_r, apb_nxt;
  logic signed [29:0] acc_r, acc_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [16:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [11:0] res_pwm_r, res_pwm_nxt;
  logic [15:0] res_norm_r, res_norm_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic               in_xfer;
  logic [10:0]        x_clamp;
  logic signed [12:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [29:0] prod;
  logic signed [29:0] sum;
  logic [11:0]        div_t;
  logic               div_q;
  logic [10:0]        div_rem;
  logic signed [12:0] ap_pwm;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    x_clamp = in_data.radio_value;
    if (x_clamp < cal_low_r) x_clamp = cal_low_r;
    if (x_clamp > cal_high_r) x_clamp = cal_high_r;
  end

  // shared multiplier
  always_comb begin
    if (is_auto_r) begin
      mul_a = $signed({1'b0, omax_r}) - $signed({1'b0, omin_r});
      mul_b = $signed({1'b0, apb_r});
    end else if (state_r == ST_MUL1) begin
      mul_a = $signed({1'b0, omax_r});
      mul_b = $signed({6'd0, d_r});
    end else begin
      mul_a = $signed({1'b0, omin_r});
      mul_b = $signed({6'd0, span_r - d_r});
    end
    prod = 30'(mul_a * mul_b);
    sum  = acc_r + prod;
  end

  // shared restoring divider step
  always_comb begin
    div_t   = {rem_r, dvd_r[16]};
    div_q   = (div_t >= {1'b0, span_r});
    div_rem = div_q ? 11'(div_t - {1'b0, span_r}) : div_t[10:0];
  end

  assign ap_pwm = $signed({1'b0, omin_r}) + acc_r[28:16];

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    last_brain_nxt = last_brain_r;
    cal_low_nxt    = cal_low_r;
    cal_high_nxt   = cal_high_r;
    is_auto_nxt    = is_auto_r;
    d_nxt          = d_r;
    span_nxt       = span_r;
    apb_nxt        = apb_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_pwm_nxt    = res_pwm_r;
    res_norm_nxt   = res_norm_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.req_type)
            REQ_TICK: begin
              if (mode_r == MODE_IDLE) begin
                res_pwm_nxt  = NEUTRAL_PWM;
                res_norm_nxt = '0;
                state_nxt    = ST_DONE;
              end
            end
            REQ_RADIO: begin
              if (mode_r == MODE_MANUAL) begin
                d_nxt       = x_clamp - cal_low_r;
                span_nxt    = cal_high_r - cal_low_r;
                is_auto_nxt = 1'b0;
                acc_nxt     = '0;
                if (cal_high_r == cal_low_r) begin
                  res_pwm_nxt  = (omin_r < NEUTRAL_PWM) ? NEUTRAL_PWM : omin_r;
                  res_norm_nxt = '0;
                  state_nxt    = ST_DONE;
                end else begin
                  state_nxt = ST_MUL0;
                end
              end else if (mode_r == MODE_CAL) begin
                if (in_data.radio_value < cal_low_r) cal_low_nxt = in_data.radio_value;
                if (in_data.radio_value > cal_high_r) cal_high_nxt = in_data.radio_value;
              end
            end
            REQ_AUTO: begin
              if (mode_r == MODE_AUTO) begin
                apb_nxt      = {~in_data.autopilot_norm[15], in_data.autopilot_norm[14:0]};
                res_norm_nxt = in_data.autopilot_norm;
                is_auto_nxt  = 1'b1;
                state_nxt    = ST_MUL0;
              end
            end
            REQ_BRAIN: begin
              if ({1'b0, in_data.brain_state} != last_brain_r) begin
                last_brain_nxt = {1'b0, in_data.brain_state};
                case (mode_r)
                  MODE_IDLE: begin
                    if (last_brain_nxt == BRAIN_MANUAL) mode_nxt = MODE_MANUAL;
                  end
                  MODE_MANUAL: begin
                    if (last_brain_nxt == BRAIN_AUTO) mode_nxt = MODE_AUTO;
                    else if (last_brain_nxt == BRAIN_IDLE) mode_nxt = MODE_IDLE;
                  end
                  MODE_AUTO: begin
                    if (last_brain_nxt == BRAIN_IDLE) mode_nxt = MODE_IDLE;
                    else if (last_brain_nxt == BRAIN_MANUAL) mode_nxt = MODE_MANUAL;
                  end
                  default: ;
                endcase
              end
            end
            REQ_CALIB: begin
              if (in_data.calib_enable) begin
                mode_nxt     = MODE_CAL;
                cal_low_nxt  = NEUTRAL_RADIO;
                cal_high_nxt = NEUTRAL_RADIO;
              end else if (mode_r == MODE_CAL) begin
                mode_nxt = MODE_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL0: begin
        acc_nxt   = prod;
        state_nxt = is_auto_r ? ST_AFIN : ST_MUL1;
      end
      ST_MUL1: begin
        // total < 4096*span, so the top 11 bits already sit below span
        rem_nxt   = sum[22:12];
        dvd_nxt   = {sum[11:0], 5'd0};
        quo_nxt   = '0;
        cnt_nxt   = 5'd12;
        state_nxt = ST_DIVP;
      end
      ST_AFIN: begin
        res_pwm_nxt = (ap_pwm[11:0] > NEUTRAL_PWM) ? NEUTRAL_PWM : ap_pwm[11:0];
        state_nxt   = ST_DONE;
      end
      ST_DIVP: begin
        quo_nxt = {quo_r[15:0], div_q};
        rem_nxt = div_rem;
        dvd_nxt = {dvd_r[15:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          res_pwm_nxt = (quo_nxt[11:0] < NEUTRAL_PWM) ? NEUTRAL_PWM : quo_nxt[11:0];
          // norm divide: (d << 16) / span, first dividend bits d >> 1 < span
          rem_nxt   = {1'b0, d_r[10:1]};
          dvd_nxt   = {d_r[0], 16'd0};
          quo_nxt   = '0;
          cnt_nxt   = 5'd17;
          state_nxt = ST_DIVN;
        end
      end
      ST_DIVN: begin
        quo_nxt = {quo_r[15:0], div_q};
        rem_nxt = div_rem;
        dvd_nxt = {dvd_r[15:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          if (quo_nxt[16] || (quo_nxt[15:0] == 16'hFFFF)) res_norm_nxt = 16'h7FFF;
          else if (!quo_nxt[15]) res_norm_nxt = '0;
          else res_norm_nxt = {1'b0, quo_nxt[14:0]};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt.pwm  = res_pwm_r;
          out_data_nxt.norm = res_norm_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_IDLE;
      last_brain_r <= BRAIN_NONE;
      cal_low_r    <= CAL_LOW_RESET;
      cal_high_r   <= CAL_HIGH_RESET;
      omin_r       <= OUT_MIN_RESET;
      omax_r       <= OUT_MAX_RESET;
      out_valid_r  <= 1'b0;
      is_auto_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      last_brain_r <= last_brain_nxt;
      cal_low_r    <= cal_low_nxt;
      cal_high_r   <= cal_high_nxt;
      out_valid_r  <= out_valid_nxt;
      is_auto_r    <= is_auto_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OUTPUT_MIN: omin_r <= cfg_data;
          CFG_OUTPUT_MAX: omax_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    span_r     <= span_nxt;
    apb_r      <= apb_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    res_pwm_r  <= res_pwm_nxt;
    res_norm_r <= res_norm_nxt;
    out_data_r <= out_data_nxt;
  end

  // calibration only ever widens a pair that starts ordered
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cal_low_r <= cal_high_r)
    else $error("calibration bounds crossed");

  // the divider never runs on a zero span and keeps its remainder below it
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVP || state_r == ST_DIVN) |-> (span_r != '0) && (rem_r < span_r))
    else $error("divider remainder out of range");

  // an idle tick reaches the output stage next cycle
  a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.req_type == REQ_TICK && mode_r == MODE_IDLE)
      |=> state_r == ST_DONE)
    else $error("idle tick lost");

  // mode does not change while an item is being worked on
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(mode_r))
    else $error("mode changed mid-item");

endmodule

`default_nettype wire

### verif/bamm_checker.sv
// ----------------------------------------------------------------------------
// bamm_checker
// Watches the request, command and register channels of the brake actuator
// mode mapper. It tracks mode, calibration bounds and output limits, works
// out the command, if any, that each accepted request should produce, and compares every
// command transfer in order, field by field.
// ----------------------------------------------------------------------------
module bamm_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  bamm_pkg::in_item_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  bamm_pkg::out_item_t out_data,
  input  wire                 cfg_valid,
  input  wire                 cfg_ready,
  input  wire                 cfg_index,
  input  wire [11:0]          cfg_data,
  output int                  fail_count,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bamm_pkg::*;

  mode_t       mode;
  logic [2:0]  last_brain;
  logic [10:0] cal_low;
  logic [10:0] cal_high;
  logic [11:0] out_min;
  logic [11:0] out_max;
  out_item_t   pending_cmds[$];

  // Advances the mode tracker by one request and queues the command it yields.
  task automatic map_request(input in_item_t req);
    out_item_t  cmd;
    logic [2:0] brain;
    longint     lo, hi, omin, omax, x, span, tot, pw, nm, a, neutral;
    lo      = cal_low;
    hi      = cal_high;
    omin    = out_min;
    omax    = out_max;
    neutral = NEUTRAL_PWM;
    brain   = {1'b0, req.brain_state};
    case (req.req_type)
      REQ_TICK: begin
        if (mode == MODE_IDLE) begin
          cmd.pwm  = NEUTRAL_PWM;
          cmd.norm = '0;
          pending_cmds.push_back(cmd);
        end
      end
      REQ_RADIO: begin
        if (mode == MODE_MANUAL) begin
          x = req.radio_value;
          if (x < lo) x = lo;
          if (x > hi) x = hi;
          span = hi - lo;
          if (span <= 0) begin
            pw = omin;
            nm = 0;
          end else begin
            // numerator never goes negative, so division floors
            tot = omin * span + (x - lo) * (omax - omin);
            pw  = tot / span;
            nm  = ((x - lo) * 65536) / span - 32768;
            if (nm < 0) nm = 0;
            if (nm > 32767) nm = 32767;
          end
          if (pw < neutral) pw = neutral;
          cmd.pwm  = pw[11:0];
          cmd.norm = nm[15:0];
          pending_cmds.push_back(cmd);
        end else if (mode == MODE_CAL) begin
          if (req.radio_value < cal_low) cal_low = req.radio_value;
          if (req.radio_value > cal_high) cal_high = req.radio_value;
        end
      end
      REQ_AUTO: begin
        if (mode == MODE_AUTO) begin
          a   = longint'($signed(req.autopilot_norm));
          tot = omin * 65536 + (a + 32768) * (omax - omin);
          pw  = tot / 65536;
          if (pw > neutral) pw = neutral;
          cmd.pwm  = pw[11:0];
          cmd.norm = req.autopilot_norm;
          pending_cmds.push_back(cmd);
        end
      end
      REQ_BRAIN: begin
        if (brain != last_brain) begin
          last_brain = brain;
          case (mode)
            MODE_IDLE: begin
              if (brain == BRAIN_MANUAL) mode = MODE_MANUAL;
            end
            MODE_MANUAL: begin
              if (brain == BRAIN_AUTO) mode = MODE_AUTO;
              else if (brain == BRAIN_IDLE) mode = MODE_IDLE;
            end
            MODE_AUTO: begin
              if (brain == BRAIN_IDLE) mode = MODE_IDLE;
              else if (brain == BRAIN_MANUAL) mode = MODE_MANUAL;
            end
            default: ;
          endcase
        end
      end
      REQ_CALIB: begin
        if (req.calib_enable) begin
          mode     = MODE_CAL;
          cal_low  = NEUTRAL_RADIO;
          cal_high = NEUTRAL_RADIO;
        end else if (mode == MODE_CAL) begin
          mode = MODE_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      mode       = MODE_IDLE;
      last_brain = BRAIN_NONE;
      cal_low    = CAL_LOW_RESET;
      cal_high   = CAL_HIGH_RESET;
      out_min    = OUT_MIN_RESET;
      out_max    = OUT_MAX_RESET;
      pending_cmds.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      // retire first: a command leaving now never belongs to a request entering now
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          $error("unexpected command transfer: pwm %0d norm %0d",
                 out_data.pwm, out_data.norm);
          errs++;
        end else begin
          want = pending_cmds.pop_front();
          if (out_data.pwm !== want.pwm) begin
            $error("pwm mismatch: expected %0d, actual %0d", want.pwm, out_data.pwm);
            errs++;
          end
          if (out_data.norm !== want.norm) begin
            $error("norm mismatch: expected %0d, actual %0d", want.norm, out_data.norm);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OUTPUT_MIN: out_min = cfg_data;
          CFG_OUTPUT_MAX: out_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) map_request(in_data);
      outstanding <= pending_cmds.size();
      fail_count  <= fail_count + errs;
    end
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the brake actuator mode mapper: a directed walk through every
// mode and request kind, then random request streams under several output
// limit settings with random stalls on both channels, one long command stall
// and a quiet final phase. Checking is done by bamm_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bamm_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         LONG_HOLD      = 300;
  localparam int         PHASE_ITEMS    = 220;
  localparam int         RADIO_MAX      = 2047;
  localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REQ_LAST_CODE    = 3'd7;
  localparam logic [2:0] BRAIN_OTHER      = 3'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_OUTPUT_MIN;
  logic [11:0] cfg_data = '0;
  int         fail_count;
  int         outstanding;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         calm_items = 0;
  int         idle_cycles = 0;

  always #10 clk = ~clk;

  brake_actuator_mode_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bamm_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // no transfer of any kind for too long means the block is hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // command side stall: random bursts, calm stretches, one long hold on request
  always begin : cmd_backpressure
    int burst;
    @(posedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      out_stall <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 16);
      out_stall <= 1'b1;
      repeat (burst) @(posedge clk);
      out_stall <= 1'b0;
    end else if (!quiet && $urandom_range(0, 59) == 0) begin
      burst = $urandom_range(40, 120);
      repeat (burst) @(posedge clk);
    end
  end

  function automatic in_item_t req_item(req_code_t code, int radio = 0, int ap = 0,
                                        logic [2:0] brain = BRAIN_IDLE, bit cal = 1'b0);
    in_item_t it;
    it.req_type       = code;
    it.radio_value    = radio[10:0];
    it.autopilot_norm = ap[15:0];
    it.brain_state    = brain[1:0];
    it.calib_enable   = cal;
    return it;
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    int       pick;
    it.radio_value    = 11'($urandom);
    it.autopilot_norm = 16'($urandom);
    it.brain_state    = 2'($urandom);
    it.calib_enable   = 1'($urandom);
    if ($urandom_range(0, 7) == 0) it.radio_value = $urandom_range(0, 1) ? 11'(RADIO_MAX) : 11'd0;
    if ($urandom_range(0, 7) == 0) it.autopilot_norm = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    pick = $urandom_range(0, 99);
    if (pick < 12)      it.req_type = REQ_TICK;
    else if (pick < 47) it.req_type = REQ_RADIO;
    else if (pick < 72) it.req_type = REQ_AUTO;
    else if (pick < 87) it.req_type = REQ_BRAIN;
    else if (pick < 95) it.req_type = REQ_CALIB;
    else it.req_type = 3'($urandom_range(int'(REQ_FIRST_UNUSED), int'(REQ_LAST_CODE)));
    return it;
  endfunction

  // one request transfer, then maybe a gap on the request side
  task automatic send_req(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (calm_items > 0) begin
      calm_items--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end else if (!quiet && $urandom_range(0, 59) == 0) begin
      calm_items = $urandom_range(20, 80);
    end
  endtask

  // stop requests and wait until every command has been seen
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [11:0] min_us, input logic [11:0] max_us);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OUTPUT_MIN;
    cfg_data  <= min_us;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_OUTPUT_MAX;
    cfg_data  <= max_us;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // forces manual mode from any mode and any last brain state
  task automatic enter_manual();
    send_req(req_item(REQ_CALIB));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_OTHER));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_IDLE));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_MANUAL));
  endtask

  task automatic calib_session(output int n);
    int k;
    k = $urandom_range(2, 8);
    send_req(req_item(REQ_CALIB, 0, 0, BRAIN_IDLE, 1'b1));
    repeat (k) send_req(req_item(REQ_RADIO, $urandom_range(0, RADIO_MAX)));
    enter_manual();
    n = k + 5;
  endtask

  task automatic run_random(input int count);
    int sent;
    int n;
    in_item_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 19) == 0) begin
        calib_session(n);
        sent += n;
      end else begin
        it = random_request();
        send_req(it);
        if (it.req_type <= REQ_CALIB) sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [11:0] min_us, input logic [11:0] max_us);
    drain();
    set_limits(min_us, max_us);
    run_random(PHASE_ITEMS);
  endtask

  initial begin
    in_item_t odd_req;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk under reset limits and bounds
    send_req(req_item(REQ_TICK));
    send_req(req_item(REQ_RADIO, 1200));
    send_req(req_item(REQ_AUTO, 0, 12345));
    odd_req = req_item(REQ_TICK);
    odd_req.req_type = REQ_FIRST_UNUSED;
    send_req(odd_req);
    odd_req.req_type = REQ_LAST_CODE;
    send_req(odd_req);
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_OTHER));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_MANUAL));
    send_req(req_item(REQ_RADIO, 0));
    send_req(req_item(REQ_RADIO, RADIO_MAX));
    send_req(req_item(REQ_RADIO, 1002));
    send_req(req_item(REQ_TICK));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_MANUAL));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_AUTO));
    send_req(req_item(REQ_AUTO, 0, -32768));
    send_req(req_item(REQ_AUTO, 0, 32767));
    send_req(req_item(REQ_AUTO, 0, 0));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_IDLE));
    send_req(req_item(REQ_CALIB, 0, 0, BRAIN_IDLE, 1'b1));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_MANUAL));
    send_req(req_item(REQ_RADIO, 1500));
    send_req(req_item(REQ_CALIB, 0, 0, BRAIN_IDLE, 1'b1));
    send_req(req_item(REQ_CALIB));
    send_req(req_item(REQ_CALIB));
    // bounds are left equal here: manual mapping sees a zero span
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_OTHER));
    send_req(req_item(REQ_BRAIN, 0, 0, BRAIN_MANUAL));
    send_req(req_item(REQ_RADIO, 700));

    run_phase(OUT_MIN_RESET, OUT_MAX_RESET);
    run_phase('0, '1);

    // long command stall with requests still offered, under inverted limits
    drain();
    set_limits('1, '0);
    enter_manual();
    hold_req = 1'b1;
    while (!out_stall) @(posedge clk);
    calm_items = 12;
    repeat (12) send_req(req_item(REQ_RADIO, $urandom_range(0, RADIO_MAX)));
    run_random(PHASE_ITEMS);

    run_phase('0, '0);
    run_phase('1, '1);
    run_phase(12'($urandom), 12'($urandom));
    run_phase(12'($urandom_range(0, 1500)), 12'($urandom_range(1500, 4095)));

    // final stretch without stalls on either side
    drain();
    quiet = 1'b1;
    set_limits(12'($urandom), 12'($urandom));
    run_random(PHASE_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
